FILE: src/gxr_pkg.sv
`default_nettype none

package gxr_pkg;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [1:0] KIND_WADDR = 2'd0;
    localparam logic [1:0] KIND_WDATA = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] ADDR_IODIRA = 8'h00;
    localparam logic [7:0] ADDR_IODIRB = 8'h01;
    localparam logic [7:0] ADDR_GPPUA  = 8'h0c;
    localparam logic [7:0] ADDR_GPPUB  = 8'h0d;
    localparam logic [7:0] ADDR_GPIOA  = 8'h12;
    localparam logic [7:0] ADDR_GPIOB  = 8'h13;
    localparam logic [7:0] ADDR_OLATA  = 8'h14;
    localparam logic [7:0] ADDR_OLATB  = 8'h15;

    localparam logic [5:0] MASK_C     = 6'b111100;
    localparam logic [5:0] FIXED_IN_C = 6'b000011;
    localparam logic [7:0] IODIR_RST  = 8'hff;

    typedef struct packed {
        logic [5:0] pullup_c;
        logic [5:0] latch_c;
        logic [5:0] dir_c;
        logic [5:0] pullup_a;
        logic [5:0] latch_a;
        logic [5:0] dir_a;
    } t_ports;

endpackage

`default_nettype wire

FILE: src/i2c_gpio_expander_registers.sv
// Path: an accepted word goes into the input register, is loaded into the
// result register when it advances, and leaves from there.
// Throughput: one word per cycle when not stalled; the register decode
// and pointer update sit in one combinational pass between the two registers.
// Reset: synchronous, active low; pointer 0, IODIR registers 0xff, all other
// register file state and the valid flags 0; data registers are not reset.
`default_nettype none

module i2c_gpio_expander_registers (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // data_byte[7:0], pins_a[13:8], pins_c[19:14], zero pad
    input  wire logic [gxr_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // kind[1:0]
    input  wire logic [gxr_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // read_data[7:0], dir_a[13:8], latch_a[19:14], pullup_a[25:20],
    // dir_c[31:26], latch_c[37:32], pullup_c[43:38], zero pad
    output logic [gxr_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata
);

    logic                          r_in_valid;
    logic [gxr_pkg::IN_DATA_W-1:0] r_in_data;
    logic [gxr_pkg::IN_USER_W-1:0] r_in_user;
    logic                          r_out_valid;
    logic [7:0]                    r_out_rd;
    gxr_pkg::t_ports               r_out_ports;
    logic                          advance;
    logic [7:0]                    rd;
    gxr_pkg::t_ports               ports;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    gxr_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_kind      (r_in_user),
        .i_data_byte (r_in_data[7:0]),
        .i_pins_a    (r_in_data[13:8]),
        .i_pins_c    (r_in_data[19:14]),
        .o_read_data (rd),
        .o_ports     (ports)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_user <= i_s_axis_tuser;
        end
        if (advance) begin
            r_out_rd    <= rd;
            r_out_ports <= ports;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'h0, r_out_ports, r_out_rd};

endmodule

`default_nettype wire

FILE: src/gxr_regfile.sv
`default_nettype none

module gxr_regfile (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic [1:0]     i_kind,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic [5:0]     i_pins_a,
    input  wire logic [5:0]     i_pins_c,
    output logic [7:0]          o_read_data,
    output gxr_pkg::t_ports     o_ports
);

    logic [7:0] r_ptr,     n_ptr;
    logic       r_expect,  n_expect;
    logic [7:0] r_iodir_a, n_iodir_a;
    logic [7:0] r_olat_a,  n_olat_a;
    logic [7:0] r_gppu_a,  n_gppu_a;
    logic [7:0] r_iodir_b, n_iodir_b;
    logic [7:0] r_olat_b,  n_olat_b;
    logic [7:0] r_gppu_b,  n_gppu_b;
    logic [7:0] rd_sel;

    always_comb begin
        case (r_ptr)
            gxr_pkg::ADDR_IODIRA: rd_sel = r_iodir_a;
            gxr_pkg::ADDR_GPIOA:  rd_sel = {2'b00, i_pins_a};
            gxr_pkg::ADDR_OLATA:  rd_sel = r_olat_a;
            gxr_pkg::ADDR_GPPUA:  rd_sel = r_gppu_a;
            gxr_pkg::ADDR_IODIRB: rd_sel = r_iodir_b;
            gxr_pkg::ADDR_GPIOB:  rd_sel = {2'b00, i_pins_c & gxr_pkg::MASK_C};
            gxr_pkg::ADDR_OLATB:  rd_sel = r_olat_b;
            gxr_pkg::ADDR_GPPUB:  rd_sel = r_gppu_b;
            default:              rd_sel = 8'h00;
        endcase
    end

    always_comb begin
        n_ptr       = r_ptr;
        n_expect    = r_expect;
        n_iodir_a   = r_iodir_a;
        n_olat_a    = r_olat_a;
        n_gppu_a    = r_gppu_a;
        n_iodir_b   = r_iodir_b;
        n_olat_b    = r_olat_b;
        n_gppu_b    = r_gppu_b;
        o_read_data = 8'h00;
        case (i_kind)
            gxr_pkg::KIND_WADDR: begin
                n_expect = 1'b1;
            end
            gxr_pkg::KIND_WDATA: begin
                if (r_expect) begin
                    n_ptr    = i_data_byte;
                    n_expect = 1'b0;
                end else begin
                    n_ptr = r_ptr + 8'd1;
                    case (r_ptr)
                        gxr_pkg::ADDR_IODIRA: n_iodir_a = i_data_byte;
                        gxr_pkg::ADDR_GPIOA,
                        gxr_pkg::ADDR_OLATA:  n_olat_a  = i_data_byte;
                        gxr_pkg::ADDR_GPPUA:  n_gppu_a  = i_data_byte;
                        gxr_pkg::ADDR_IODIRB: n_iodir_b = i_data_byte;
                        gxr_pkg::ADDR_GPIOB,
                        gxr_pkg::ADDR_OLATB:  n_olat_b  = i_data_byte;
                        gxr_pkg::ADDR_GPPUB:  n_gppu_b  = i_data_byte;
                        default: ;
                    endcase
                end
            end
            gxr_pkg::KIND_READ: begin
                o_read_data = rd_sel;
                n_ptr       = r_ptr + 8'd1;
            end
            default: ;
        endcase
    end

    // port outputs show the state after this word
    always_comb begin
        o_ports.dir_a    = n_iodir_a[5:0];
        o_ports.latch_a  = n_olat_a[5:0];
        o_ports.pullup_a = n_gppu_a[5:0];
        o_ports.dir_c    = gxr_pkg::FIXED_IN_C | (n_iodir_b[5:0] & gxr_pkg::MASK_C);
        o_ports.latch_c  = n_olat_b[5:0] & gxr_pkg::MASK_C;
        o_ports.pullup_c = n_gppu_b[5:0] & gxr_pkg::MASK_C;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= 8'h00;
            r_expect  <= 1'b0;
            r_iodir_a <= gxr_pkg::IODIR_RST;
            r_olat_a  <= 8'h00;
            r_gppu_a  <= 8'h00;
            r_iodir_b <= gxr_pkg::IODIR_RST;
            r_olat_b  <= 8'h00;
            r_gppu_b  <= 8'h00;
        end else if (i_en) begin
            r_ptr     <= n_ptr;
            r_expect  <= n_expect;
            r_iodir_a <= n_iodir_a;
            r_olat_a  <= n_olat_a;
            r_gppu_a  <= n_gppu_a;
            r_iodir_b <= n_iodir_b;
            r_olat_b  <= n_olat_b;
            r_gppu_b  <= n_gppu_b;
        end
    end

    a_waddr_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == gxr_pkg::KIND_WADDR) |=> r_expect)
        else $error("write address did not arm pointer load");

    a_ptr_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == gxr_pkg::KIND_WDATA && r_expect)
        |=> (!r_expect && r_ptr == $past(i_data_byte)))
        else $error("pointer load failed");

    a_read_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == gxr_pkg::KIND_READ) |=> r_ptr == $past(r_ptr) + 8'd1)
        else $error("pointer did not advance on read");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_ptr) && $stable(r_expect)))
        else $error("state changed without a word");

endmodule

`default_nettype wire
